[hdl/urb_pkg.sv]
// Shared types and constants for the UART ring buffer with RS-485 control.
package urb_pkg;

  localparam int unsigned RxDepthDefault = 64;
  localparam int unsigned TxDepthDefault = 64;
  localparam int unsigned DataW          = 8;
  localparam int unsigned LevelW         = 7;

  localparam logic [DataW-1:0] CrByte = 8'h0d;

  typedef enum logic [1:0] {
    CmdPut  = 2'd0,
    CmdGet  = 2'd1,
    CmdRx   = 2'd2,
    CmdThre = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [DataW-1:0] data;
    logic             transmitter_ready;
    logic             assert_driver;
  } in_t;

  typedef struct packed {
    logic              tx_valid;
    logic [DataW-1:0]  tx_byte;
    logic              put_accepted;
    logic              rd_valid;
    logic [DataW-1:0]  rd_byte;
    logic              rx_overflow;
    logic              driver_enable;
    logic              last_rx_was_cr;
    logic [LevelW-1:0] rx_level;
    logic [LevelW-1:0] tx_level;
  } out_t;

endpackage

[hdl/uart_ring_buffer_rs485_core.sv]
// Top level: UART receive/transmit ring queues with RS-485 driver-enable control.
// Each item is handled in two steps: when it is taken in idle the head entries
// of both queue memories are read (registered read); in the execute state the
// item is resolved, the queue memory is written and pointers, counts and
// flags are updated, and the result is loaded into the output register.
// A new item is taken as soon as the block is back in idle, even while the
// previous result still waits at the output; the execute state only holds
// when that output register is still occupied and stalled. Queue memories
// need no clearing after reset: the fill counts keep every read on written
// entries. The overflow flag is sticky until reset.
module uart_ring_buffer_rs485_core import urb_pkg::*; #(
  parameter int unsigned RX_DEPTH = RxDepthDefault,
  parameter int unsigned TX_DEPTH = TxDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_item_o
);

  localparam int unsigned RxCW = $clog2(RX_DEPTH + 1);
  localparam int unsigned TxCW = $clog2(TX_DEPTH + 1);

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  state_e state_q;
  in_t    item_q;
  logic   out_valid_q;
  out_t   out_q, res;
  logic   ovf_q, ovf_d, drv_q, drv_d, cr_q, cr_d;
  logic   accept, fire;

  logic             rx_push, rx_pop, rx_zero;
  logic             tx_push, tx_pop;
  logic [DataW-1:0] rx_rdata, tx_rdata;
  logic [RxCW-1:0]  rx_fill, rx_fill_next;
  logic [TxCW-1:0]  tx_fill, tx_fill_next;

  urb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rx_push),
    .pop_i       (rx_pop),
    .zero_i      (rx_zero),
    .wdata_i     (item_q.data),
    .rdata_o     (rx_rdata),
    .fill_o      (rx_fill),
    .fill_next_o (rx_fill_next)
  );

  urb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (tx_push),
    .pop_i       (tx_pop),
    .zero_i      (1'b0),
    .wdata_i     (item_q.data),
    .rdata_o     (tx_rdata),
    .fill_o      (tx_fill),
    .fill_next_o (tx_fill_next)
  );

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);
  assign fire       = (state_q == StExec) && (!out_valid_q || !out_stall_i);

  always_comb begin
    res     = '0;
    rx_push = 1'b0;
    rx_pop  = 1'b0;
    rx_zero = 1'b0;
    tx_push = 1'b0;
    tx_pop  = 1'b0;
    ovf_d   = ovf_q;
    drv_d   = drv_q;
    cr_d    = cr_q;
    if (fire) begin
      case (item_q.cmd)
        CmdPut: begin
          if (item_q.assert_driver) begin
            drv_d = 1'b1;
          end
          if (tx_fill == TxCW'(TX_DEPTH)) begin
            res.put_accepted = 1'b0;
          end else if (tx_fill != '0 || !item_q.transmitter_ready) begin
            tx_push          = 1'b1;
            res.put_accepted = 1'b1;
          end else begin
            // line idle and nothing queued: hand the byte straight over
            res.tx_valid     = 1'b1;
            res.tx_byte      = item_q.data;
            res.put_accepted = 1'b1;
          end
        end
        CmdGet: begin
          if (rx_fill != '0) begin
            rx_pop       = 1'b1;
            res.rd_valid = 1'b1;
            res.rd_byte  = rx_rdata;
          end
        end
        CmdRx: begin
          rx_push = 1'b1;
          rx_zero = (rx_fill == RxCW'(RX_DEPTH - 1));
          if (rx_zero) begin
            ovf_d = 1'b1;
          end
          cr_d = (item_q.data == CrByte);
        end
        CmdThre: begin
          if (tx_fill != '0) begin
            tx_pop       = 1'b1;
            res.tx_valid = 1'b1;
            res.tx_byte  = tx_rdata;
          end else begin
            drv_d = 1'b0;
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end
    res.rx_overflow    = ovf_d;
    res.driver_enable  = drv_d;
    res.last_rx_was_cr = cr_d;
    res.rx_level       = LevelW'(rx_fill_next);
    res.tx_level       = LevelW'(tx_fill_next);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      ovf_q       <= 1'b0;
      drv_q       <= 1'b0;
      cr_q        <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          if (fire) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
      if (fire) begin
        out_valid_q <= 1'b1;
        out_q       <= res;
        ovf_q       <= ovf_d;
        drv_q       <= drv_d;
        cr_q        <= cr_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_fire_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o && state_q == StIdle)
    else $error("result not loaded after update cycle");

  a_one_byte_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.tx_valid && out_item_o.rd_valid))
    else $error("transmit and read both flagged for one item");

  a_rx_fill_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_fill < RxCW'(RX_DEPTH))
    else $error("receive count reached depth without wrapping");

  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared outside reset");

endmodule

[hdl/urb_ring.sv]
// Ring queue: byte memory with registered read, read and write pointers, fill count.
module urb_ring import urb_pkg::*; #(
  parameter int unsigned DEPTH = RxDepthDefault,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             pop_i,
  input  logic             zero_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o,
  output logic [CW-1:0]    fill_o,
  output logic [CW-1:0]    fill_next_o
);

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rdata_q;
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    fill_q, fill_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      // a push that completes a full ring drops the count back to zero
      fill_d = zero_i ? '0 : fill_q + CW'(1);
    end else if (pop_i) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      fill_d = fill_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // head entry is read every cycle; writes land before the next item is taken
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
    rdata_q <= mem_q[rptr_q];
  end

  assign rdata_o     = rdata_q;
  assign fill_o      = fill_q;
  assign fill_next_o = fill_d;

  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && pop_i))
    else $error("ring pushed and popped in the same cycle");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> fill_q != '0)
    else $error("ring popped while empty");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("ring fill count beyond depth");

endmodule

[test/uart_ring_buffer_rs485_core_tb.sv]
// Testbench for the UART ring buffer core: random and directed items checked against a predictor.
`timescale 1ns / 100ps

module uart_ring_buffer_rs485_core_tb;
  import urb_pkg::*;

  localparam int unsigned RxDepth    = RxDepthDefault;
  localparam int unsigned TxDepth    = TxDepthDefault;
  localparam int unsigned RandItems  = 800;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 20;

  typedef enum int {PhTxFill, PhTxDrain, PhRxFill, PhRxDrain, PhMixed} phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_item;

  in_t  pending_items[$];
  out_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Predictor state
  logic [DataW-1:0] rx_mem[RxDepth];
  logic [DataW-1:0] tx_mem[TxDepth];
  int unsigned rx_wr = 0, rx_rd = 0, rx_count = 0;
  int unsigned tx_wr = 0, tx_rd = 0, tx_count = 0;
  logic overflow_seen = 1'b0, drv_on = 1'b0, cr_flag = 1'b0;

  uart_ring_buffer_rs485_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #5 clk_i = ~clk_i;

  function automatic out_t resolve_item(in_t it);
    out_t r;
    r = '0;
    case (it.cmd)
      CmdPut: begin
        if (it.assert_driver) drv_on = 1'b1;
        if (tx_count >= TxDepth) begin
          r.put_accepted = 1'b0;
        end else if (tx_count != 0 || !it.transmitter_ready) begin
          tx_mem[tx_wr] = it.data;
          tx_wr = (tx_wr + 1) % TxDepth;
          tx_count++;
          r.put_accepted = 1'b1;
        end else begin
          r.tx_valid = 1'b1;
          r.tx_byte = it.data;
          r.put_accepted = 1'b1;
        end
      end
      CmdGet: begin
        if (rx_count != 0) begin
          r.rd_valid = 1'b1;
          r.rd_byte = rx_mem[rx_rd];
          rx_rd = (rx_rd + 1) % RxDepth;
          rx_count--;
        end
      end
      CmdRx: begin
        rx_mem[rx_wr] = it.data;
        rx_wr = (rx_wr + 1) % RxDepth;
        rx_count++;
        // wrap the count and lose the unread bytes
        if (rx_count >= RxDepth) begin
          rx_count = 0;
          overflow_seen = 1'b1;
        end
        cr_flag = (it.data == CrByte);
      end
      default: begin
        if (tx_count != 0) begin
          tx_count--;
          r.tx_valid = 1'b1;
          r.tx_byte = tx_mem[tx_rd];
          tx_rd = (tx_rd + 1) % TxDepth;
        end else begin
          drv_on = 1'b0;
        end
      end
    endcase
    r.rx_overflow = overflow_seen;
    r.driver_enable = drv_on;
    r.last_rx_was_cr = cr_flag;
    r.rx_level = LevelW'(rx_count);
    r.tx_level = LevelW'(tx_count);
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    if (mismatches < 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) note_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
  endtask

  task automatic check_result(out_t want, out_t got);
    check_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
    check_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
    check_field("put_accepted", 32'(want.put_accepted), 32'(got.put_accepted));
    check_field("rd_valid", 32'(want.rd_valid), 32'(got.rd_valid));
    check_field("rd_byte", 32'(want.rd_byte), 32'(got.rd_byte));
    check_field("rx_overflow", 32'(want.rx_overflow), 32'(got.rx_overflow));
    check_field("driver_enable", 32'(want.driver_enable), 32'(got.driver_enable));
    check_field("last_rx_was_cr", 32'(want.last_rx_was_cr), 32'(got.last_rx_was_cr));
    check_field("rx_level", 32'(want.rx_level), 32'(got.rx_level));
    check_field("tx_level", 32'(want.tx_level), 32'(got.tx_level));
  endtask

  task automatic add_item(cmd_e c, logic [DataW-1:0] d, logic rdy, logic drv);
    in_t it;
    it.cmd = c;
    it.data = d;
    it.transmitter_ready = rdy;
    it.assert_driver = drv;
    pending_items.push_back(it);
  endtask

  // Sender: bursts of items separated by random gaps
  int unsigned burst_left = 4;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(resolve_item(in_item));
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(30, 1);
            gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks results and picks a new random stall mode whenever its mode counter runs out
  int unsigned stall_mode = 0;
  int unsigned mode_cycles = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result %p", out_item));
        end else begin
          check_result(expected_results.pop_front(), out_item);
        end
      end
      if (mode_cycles == 0) begin
        stall_mode = $urandom_range(3, 0);
        mode_cycles = 64;
      end
      mode_cycles--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3, 0) == 0);
        2: out_stall <= ($urandom_range(3, 0) != 0);
        default: out_stall <= mode_cycles[0];
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned n_rand;
    int unsigned ph_len;
    int unsigned round;
    phase_e ph;
    cmd_e c;
    logic [DataW-1:0] d;

    // Directed: direct send, queued puts, drain, driver drop, CR tracking, empty get
    add_item(CmdGet, 8'h00, 1'b0, 1'b0);
    add_item(CmdThre, 8'hff, 1'b1, 1'b1);
    add_item(CmdPut, 8'h00, 1'b1, 1'b1);
    add_item(CmdThre, 8'h00, 1'b0, 1'b0);
    add_item(CmdPut, 8'hff, 1'b0, 1'b0);
    add_item(CmdPut, 8'ha5, 1'b1, 1'b1);
    add_item(CmdPut, 8'h5a, 1'b1, 1'b0);
    add_item(CmdThre, 8'h00, 1'b0, 1'b0);
    add_item(CmdThre, 8'h00, 1'b0, 1'b0);
    add_item(CmdThre, 8'h00, 1'b0, 1'b0);
    add_item(CmdThre, 8'h00, 1'b0, 1'b0);
    add_item(CmdRx, CrByte, 1'b1, 1'b1);
    add_item(CmdRx, 8'h00, 1'b0, 1'b0);
    add_item(CmdRx, 8'hff, 1'b0, 1'b0);
    add_item(CmdRx, CrByte, 1'b0, 1'b0);
    add_item(CmdGet, 8'hff, 1'b1, 1'b1);
    add_item(CmdGet, 8'h00, 1'b0, 1'b0);
    add_item(CmdGet, 8'h00, 1'b0, 1'b0);
    add_item(CmdGet, 8'h00, 1'b0, 1'b0);
    add_item(CmdGet, 8'h00, 1'b0, 1'b0);
    add_item(CmdPut, 8'h3c, 1'b1, 1'b0);

    // Random: phases that fill and drain each queue. The first round uses only the
    // phase's own command, long enough to fill the transmit queue and wrap the receive one.
    n_rand = 0;
    round = 0;
    while (n_rand < RandItems) begin
      for (int p = 0; p < 5 && n_rand < RandItems; p++) begin
        ph = phase_e'(p);
        ph_len = (round == 0) ? $urandom_range(110, 70) : $urandom_range(110, 30);
        for (int k = 0; k < ph_len && n_rand < RandItems; k++) begin
          case (ph)
            PhTxFill:  c = CmdPut;
            PhTxDrain: c = CmdThre;
            PhRxFill:  c = CmdRx;
            PhRxDrain: c = CmdGet;
            default:   c = cmd_e'($urandom_range(3, 0));
          endcase
          if (round != 0 && $urandom_range(4, 0) == 0) c = cmd_e'($urandom_range(3, 0));
          d = DataW'($urandom_range(255, 0));
          if (c == CmdRx && $urandom_range(7, 0) == 0) d = CrByte;
          add_item(c, d, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
          n_rand++;
        end
      end
      round++;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DrainWait) @(posedge clk_i);

    if (expected_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/urb_pkg.sv
hdl/urb_ring.sv
hdl/uart_ring_buffer_rs485_core.sv
test/uart_ring_buffer_rs485_core_tb.sv
